[rtl/spm_pkg.sv]
// Shared types and constants for the servo pulse multiplexer.
`default_nettype none

package spm_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_BITS = 3;
  localparam int TICK_BITS = 16;
  localparam int SERVO_COUNT_BITS = 4;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam int S_TDATA_BITS = 64;

  localparam logic [3:0] SERVO_COUNT_RESET = 4'd8;
  localparam logic [15:0] CYCLE_TOP_RESET = 16'hFFFF;

  // Offset that moves the signed speed onto -1..254 (0..254 for speeds from -127 up).
  localparam logic signed [8:0] SPEED_BIAS = 9'sd127;

  // ceil(2^32 / 254): exact floor division by 254 for magnitudes below 2^24.
  localparam logic [24:0] RECIP_254 = 25'd16909321;

  localparam logic FUNC_SET = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SERVO_COUNT = 1'b0,
    CFG_CYCLE_TOP   = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

[rtl/servo_pulse_multiplexer.sv]
// Top level of the servo pulse multiplexer: set pipeline, channel sequencer and output register.
`default_nettype none

// One beat is accepted per clock while s_tready is high. Every beat passes three register
// stages in order (input, product, quotient), and a tick beat then lands in the output
// register. The set path uses the second and third stages for the speed-by-span product and
// the reciprocal multiply that divides it by 254; the table, channel and running minimum all
// change in the last stage, so a tick always sees every earlier set. A stall on the output
// holds a tick in the last stage and every occupied stage behind it, and s_tready stays
// high while any stage is free. Configuration writes are always accepted and are meant for
// an idle block.
module servo_pulse_multiplexer import spm_pkg::*; #(
  parameter int SELECT_BITS = 3
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  // [2:0] servo_index, [10:3] speed, [26:11] lo_ticks, [42:27] hi_ticks,
  // [43] connected, [59:44] counter_sample, [63:60] zero
  input  wire  [S_TDATA_BITS-1:0]     s_tdata,
  // [0] func
  input  wire                         s_tuser,
  output logic                        m_tvalid,
  input  wire                         m_tready,
  // [SELECT_BITS-1:0] mux_select, then pulse_width (16), then min_counter (16), zero fill
  output logic [((SELECT_BITS+2*TICK_BITS+7)/8)*8-1:0] m_tdata,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire  [CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int M_BITS = ((SELECT_BITS + 2*TICK_BITS + 7) / 8) * 8;
  localparam int M_PAD = M_BITS - SELECT_BITS - 2*TICK_BITS;

  // Stage 1: input register.
  logic                  v1;
  logic                  func1;
  logic [CH_BITS-1:0]    idx1;
  logic signed [7:0]     speed1;
  logic [TICK_BITS-1:0]  lo1;
  logic [TICK_BITS-1:0]  hi1;
  logic                  conn1;
  logic [TICK_BITS-1:0]  sample1;

  // Stage 2: product register.
  logic                  v2;
  logic                  func2;
  logic [CH_BITS-1:0]    idx2;
  logic signed [25:0]    prod2;
  logic [TICK_BITS-1:0]  lo2;
  logic                  conn2;
  logic [TICK_BITS-1:0]  sample2;

  // Stage 3: quotient register.
  logic                  v3;
  logic                  func3;
  logic [CH_BITS-1:0]    idx3;
  logic                  neg3;
  logic [TICK_BITS-1:0]  quot3;
  logic [TICK_BITS-1:0]  lo3;
  logic                  conn3;
  logic [TICK_BITS-1:0]  sample3;

  // Architectural state.
  logic [SERVO_COUNT_BITS-1:0] servo_count;
  logic [CH_BITS-1:0]          channel;
  logic [TICK_BITS-1:0]        running_min;
  logic [TICK_BITS-1:0]        pulse_table [CHANNELS];
  logic [CHANNELS-1:0]         connected_flags;

  logic out_free, go3, ld3, go2, ld2, ld1;
  logic s_accept, cfg_accept;

  logic signed [8:0]  bias_speed;
  logic signed [16:0] span;
  logic signed [25:0] prod_next;
  logic [25:0]        mag_full;
  logic [48:0]        recip_prod;
  logic [TICK_BITS-1:0] signed_quot;
  logic [TICK_BITS-1:0] ticks;
  logic [TICK_BITS-1:0] width_set;

  logic [CH_BITS-1:0]   channel_next;
  logic [CH_BITS-1:0]   follow;
  logic [TICK_BITS-1:0] running_min_next;
  logic [TICK_BITS-1:0] stored;
  logic [TICK_BITS-1:0] pulse_next;
  logic                 in_use;
  logic [7:0]           channel_wide;

  assign out_free = !m_tvalid || m_tready;
  assign go3 = v3 && ((func3 == FUNC_SET) || out_free);
  assign ld3 = !v3 || go3;
  assign go2 = v2 && ld3;
  assign ld2 = !v2 || go2;
  assign ld1 = !v1 || (v1 && ld2);
  assign s_tready = ld1;
  assign s_accept = s_tvalid && ld1;
  assign cfg_ready = 1'b1;
  assign cfg_accept = cfg_valid;

  // Set path arithmetic, one multiplier after each of the input and product stages.
  always_comb begin
    bias_speed = {speed1[7], speed1} + SPEED_BIAS;
    span = $signed({1'b0, hi1}) - $signed({1'b0, lo1});
    prod_next = bias_speed * span;
    mag_full = prod2[25] ? (26'd0 - prod2) : prod2;
    recip_prod = {25'd0, mag_full[23:0]} * {24'd0, RECIP_254};
    signed_quot = neg3 ? (16'd0 - quot3) : quot3;
    ticks = signed_quot + lo3;
    width_set = {ticks[TICK_BITS-4:0], 3'b000};
  end

  // Tick path: advance, lower the minimum, fetch the following channel.
  always_comb begin
    channel_next = channel + 3'd1;
    follow = channel_next + 3'd1;
    running_min_next = (sample3 < running_min) ? sample3 : running_min;
    in_use = {1'b0, follow} < servo_count;
    stored = pulse_table[follow];
    if (in_use && connected_flags[follow]) begin
      pulse_next = (stored > running_min_next) ? running_min_next : stored;
    end else begin
      pulse_next = '0;
    end
    channel_wide = {5'd0, channel_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      m_tvalid <= 1'b0;
      servo_count <= SERVO_COUNT_RESET;
      channel <= SERVO_COUNT_RESET[CH_BITS-1:0];
      running_min <= CYCLE_TOP_RESET;
      connected_flags <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pulse_table[i] <= '0;
      end
    end else begin
      if (ld1) begin
        v1 <= s_tvalid;
      end
      if (ld2) begin
        v2 <= v1;
      end
      if (ld3) begin
        v3 <= v2;
      end

      if (go3 && (func3 == FUNC_TICK)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (go3 && (func3 == FUNC_SET)) begin
        pulse_table[idx3] <= width_set;
        connected_flags[idx3] <= conn3;
      end

      if (cfg_accept) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_SERVO_COUNT: begin
            servo_count <= cfg_data[SERVO_COUNT_BITS-1:0];
            channel <= cfg_data[CH_BITS-1:0];
          end
          CFG_CYCLE_TOP: begin
            running_min <= cfg_data[TICK_BITS-1:0];
          end
          default: begin
          end
        endcase
      end else if (go3 && (func3 == FUNC_TICK)) begin
        channel <= channel_next;
        running_min <= running_min_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      func1 <= s_tuser;
      idx1 <= s_tdata[2:0];
      speed1 <= s_tdata[10:3];
      lo1 <= s_tdata[26:11];
      hi1 <= s_tdata[42:27];
      conn1 <= s_tdata[43];
      sample1 <= s_tdata[59:44];
    end
    if (ld2 && v1) begin
      func2 <= func1;
      idx2 <= idx1;
      prod2 <= prod_next;
      lo2 <= lo1;
      conn2 <= conn1;
      sample2 <= sample1;
    end
    if (ld3 && v2) begin
      func3 <= func2;
      idx3 <= idx2;
      neg3 <= prod2[25];
      quot3 <= recip_prod[47:32];
      lo3 <= lo2;
      conn3 <= conn2;
      sample3 <= sample2;
    end
    if (go3 && (func3 == FUNC_TICK)) begin
      m_tdata <= {{M_PAD{1'b0}}, running_min_next, pulse_next,
                  channel_wide[SELECT_BITS-1:0]};
    end
  end

endmodule

`default_nettype wire

[rtl/spm_checker.sv]
// Port-level checks for the servo pulse multiplexer and the bind that attaches them.
`default_nettype none

module spm_checker import spm_pkg::*; #(
  parameter int SELECT_BITS = 3
) (
  input wire                       clk,
  input wire                       rst,
  input wire                       m_tvalid,
  input wire                       m_tready,
  input wire [((SELECT_BITS+2*TICK_BITS+7)/8)*8-1:0] m_tdata
);

  logic [TICK_BITS-1:0] pulse_width;
  logic [TICK_BITS-1:0] min_counter;

  assign pulse_width = m_tdata[SELECT_BITS +: TICK_BITS];
  assign min_counter = m_tdata[SELECT_BITS+TICK_BITS +: TICK_BITS];

  // A held result beat keeps its value until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // The pulse width never exceeds the running minimum it is clamped to.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pulse_width <= min_counter)
    else $error("pulse width above running minimum");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat present after reset");

endmodule

bind servo_pulse_multiplexer spm_checker #(.SELECT_BITS(SELECT_BITS)) u_spm_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

`default_nettype wire

[sim/servo_pulse_multiplexer_tb.sv]
// Self-checking testbench for the servo pulse multiplexer: directed and random beats.
`default_nettype none

module servo_pulse_multiplexer_tb import spm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 1000;
  localparam int PHASES = 10;
  localparam int PHASE_CMDS = 185;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic        func;
    logic [2:0]  idx;
    logic [7:0]  speed;
    logic [15:0] lo;
    logic [15:0] hi;
    logic        conn;
    logic [15:0] sample;
  } servo_cmd_t;

  localparam int CMD_BITS = $bits(servo_cmd_t);

  typedef struct packed {
    logic [2:0]  sel;
    logic [15:0] width;
    logic [15:0] floor_val;
  } pulse_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  servo_pulse_multiplexer #(.SELECT_BITS(3)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  servo_cmd_t cmd_q[$];
  pulse_t     pulse_q[$];
  int         mismatches = 0;

  logic [3:0]  servo_cnt;
  logic [2:0]  cur_chan;
  logic [15:0] floor_cnt;
  logic [15:0] slot_width[CHANNELS];
  logic        slot_live[CHANNELS];

  initial forever #6 clk = ~clk;

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic logic [15:0] scaled_width(logic [7:0] spd, logic [15:0] lo, logic [15:0] hi);
    longint v;
    logic [15:0] t;
    v = (longint'($signed(spd)) + 127) * (longint'(hi) - longint'(lo));
    v = v / 254 + longint'(lo);
    t = v[15:0];
    return {t[12:0], 3'b000};
  endfunction

  task automatic apply_servo_cmd(servo_cmd_t c);
    logic [2:0]  nxt;
    logic [15:0] w;
    pulse_t      p;
    if (c.func == FUNC_SET) begin
      slot_width[c.idx] = scaled_width(c.speed, c.lo, c.hi);
      slot_live[c.idx] = c.conn;
    end else begin
      cur_chan = cur_chan + 3'd1;
      if (c.sample < floor_cnt) floor_cnt = c.sample;
      nxt = cur_chan + 3'd1;
      w = '0;
      if ({1'b0, nxt} < servo_cnt && slot_live[nxt]) begin
        w = slot_width[nxt];
        if (w > floor_cnt) w = floor_cnt;
      end
      p.sel = cur_chan;
      p.width = w;
      p.floor_val = floor_cnt;
      pulse_q.push_back(p);
    end
  endtask

  function automatic servo_cmd_t set_cmd(logic [2:0] idx, logic [7:0] spd, logic [15:0] lo,
                                         logic [15:0] hi, logic conn);
    servo_cmd_t c;
    c = '0;
    c.func = FUNC_SET;
    c.idx = idx;
    c.speed = spd;
    c.lo = lo;
    c.hi = hi;
    c.conn = conn;
    return c;
  endfunction

  function automatic servo_cmd_t tick_cmd(logic [15:0] sample);
    servo_cmd_t c;
    c = '0;
    c.func = FUNC_TICK;
    c.sample = sample;
    return c;
  endfunction

  // Unused fields carry random noise on every random beat.
  function automatic servo_cmd_t random_cmd();
    servo_cmd_t c;
    c = servo_cmd_t'(CMD_BITS'({$urandom, $urandom}));
    c.func = ($urandom_range(0, 99) < 35) ? FUNC_SET : FUNC_TICK;
    if (c.func == FUNC_SET) begin
      if ($urandom_range(0, 3) != 0) begin
        c.lo = 16'($urandom_range(500, 3000));
        c.hi = 16'($urandom_range(3000, 8000));
      end
      c.conn = ($urandom_range(0, 4) != 0);
    end else if ($urandom_range(0, 19) != 0) begin
      c.sample = 16'($urandom_range(40000, 65535));
    end
    return c;
  endfunction

  task automatic cfg_write(cfg_reg_t idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SERVO_COUNT) begin
      servo_cnt = val[3:0];
      cur_chan = val[2:0];
    end else begin
      floor_cnt = val;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (cmd_q.size() != 0 || s_tvalid || pulse_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  // Driver: bursts of beats separated by random gaps.
  servo_cmd_t cur_cmd;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) apply_servo_cmd(cur_cmd);
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, cur_cmd.sample, cur_cmd.conn, cur_cmd.hi, cur_cmd.lo,
                      cur_cmd.speed, cur_cmd.idx};
          s_tuser <= cur_cmd.func;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls in modes of its own.
  pulse_t want;
  int     stall_mode = 0;
  int     mode_left = 0;
  int     cyc = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pulse_q.size() == 0) begin
          report_mismatch("unexpected result beat, mux_select", 16'(m_tdata[2:0]), 16'd0);
        end else begin
          want = pulse_q.pop_front();
          if (m_tdata[2:0] !== want.sel)
            report_mismatch("mux_select", 16'(m_tdata[2:0]), 16'(want.sel));
          if (m_tdata[18:3] !== want.width)
            report_mismatch("pulse_width", m_tdata[18:3], want.width);
          if (m_tdata[34:19] !== want.floor_val)
            report_mismatch("min_counter", m_tdata[34:19], want.floor_val);
        end
      end
      cyc++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 150);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= (cyc % 4) == 0;
        default: m_tready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Watchdog on cycles without any accepted beat.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int sc_plan[PHASES] = '{0, 15, 8, 1, 7, 3, 8, 9, 5, 8};

  initial begin
    logic [15:0] top;
    servo_cnt = SERVO_COUNT_RESET;
    cur_chan = SERVO_COUNT_RESET[2:0];
    floor_cnt = CYCLE_TOP_RESET;
    for (int i = 0; i < CHANNELS; i++) begin
      slot_width[i] = '0;
      slot_live[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Speed extremes, -128, min above max, width overflow, idle channels and clamping.
    cmd_q.push_back(tick_cmd(16'hFFFF));
    cmd_q.push_back(set_cmd(3'd0, 8'sd127, 16'd1000, 16'd2000, 1'b1));
    cmd_q.push_back(set_cmd(3'd1, -8'sd127, 16'd1000, 16'd2000, 1'b1));
    cmd_q.push_back(set_cmd(3'd2, 8'sd0, 16'd1000, 16'd2000, 1'b1));
    cmd_q.push_back(set_cmd(3'd3, 8'h80, 16'd1000, 16'd2000, 1'b1));
    cmd_q.push_back(set_cmd(3'd4, 8'sd5, 16'hFFFF, 16'h0000, 1'b1));
    cmd_q.push_back(set_cmd(3'd5, 8'sd127, 16'd1500, 16'd2500, 1'b0));
    cmd_q.push_back(set_cmd(3'd6, 8'sd127, 16'h0000, 16'hFFFF, 1'b1));
    cmd_q.push_back(set_cmd(3'd7, 8'h80, 16'h0000, 16'hFFFF, 1'b1));
    for (int i = 0; i < 8; i++) cmd_q.push_back(tick_cmd(16'(65535 - i * 1000)));
    cmd_q.push_back(tick_cmd(16'd9000));
    cmd_q.push_back(tick_cmd(16'd0));
    cmd_q.push_back(tick_cmd(16'hFFFF));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: top = 16'd0;
        1: top = 16'hFFFF;
        2: top = 16'd1;
        default: top = 16'($urandom_range(30000, 65535));
      endcase
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(CFG_SERVO_COUNT, 16'(sc_plan[ph]));
        cfg_write(CFG_CYCLE_TOP, top);
      end else begin
        cfg_write(CFG_CYCLE_TOP, top);
        cfg_write(CFG_SERVO_COUNT, 16'(sc_plan[ph]));
      end
      cfg_valid <= 1'b0;
      for (int i = 0; i < PHASE_CMDS; i++) cmd_q.push_back(random_cmd());
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/spm_pkg.sv
rtl/servo_pulse_multiplexer.sv
rtl/spm_checker.sv
sim/servo_pulse_multiplexer_tb.sv
